// ===== hw/rtl/gie_pkg.sv =====
// Package for the GPIO edge interrupt event block: port count, config
// register indexes, controller states, command/status structs, helpers.
// No dependencies.
package gie_pkg;

    localparam int PORT_COUNT = 4;
    localparam int SLOT_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int CFG_PORTS  = 4;   // ports that have bytes in the 32-bit masks

    typedef enum logic [1:0] {
        CFG_IRQ_ENABLE   = 2'd0,
        CFG_FALLING_SEL  = 2'd1,
        CFG_BOTH_EDGES   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } gie_state_t;

    typedef struct packed {
        logic load;   // take the input sample and update port state
        logic pop;    // current event transferred, retire lowest pending pin
    } gie_cmd_t;

    typedef struct packed {
        logic new_any;     // incoming sample raises at least one event
        logic rest_empty;  // pending event is the last of its sample
    } gie_status_t;

    // Byte of a per-port mask for a zero-based port slot; slots without
    // mask bits read as zero.
    function automatic logic [7:0] port_byte(input logic [31:0] mask,
                                             input logic [2:0]  slot);
        logic [31:0] sh;
        sh = mask >> {slot[1:0], 3'b000};
        port_byte = (32'(slot) >= 32'(CFG_PORTS)) ? 8'h00 : sh[7:0];
    endfunction

    // Index of the lowest set bit, zero when none is set.
    function automatic logic [2:0] lowest_pin(input logic [7:0] bits);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (bits[i])
            begin
                idx = 3'(i);
            end
        end
        lowest_pin = idx;
    endfunction

endpackage

// ===== hw/rtl/gie_ctrl.sv =====
// Controller for the GPIO edge interrupt event block: sample/drain FSM.
// Depends on gie_pkg.
module gie_ctrl
    import gie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  gie_status_t status,
    output gie_cmd_t    cmd
);

    gie_state_t state_reg;
    gie_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
        cmd.load  = 1'b0;
        cmd.pop   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                cmd.pop   = !out_stall;
                // a new sample may enter on the transfer of the final event
                in_stall  = !(!out_stall && status.rest_empty);
                cmd.load  = in_valid && !out_stall && status.rest_empty;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.new_any)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!out_stall && status.rest_empty)
                begin
                    state_next = (in_valid && status.new_any) ? ST_DRAIN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/gie_datapath.sv =====
// Datapath for the GPIO edge interrupt event block: config masks, per-port
// levels and edge sense, edge detection and pending-event drain.
// Depends on gie_pkg.
module gie_datapath
    import gie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gie_cmd_t    cmd,
    output gie_status_t status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [2:0]  port_number,
    input  logic [7:0]  pin_levels,
    output logic [2:0]  event_port,
    output logic [2:0]  event_pin,
    output logic        last_event
);

    logic [31:0] enable_reg;
    logic [31:0] falling_reg;
    logic [31:0] both_reg;
    logic [7:0]  prev_reg  [PORT_COUNT];
    logic [7:0]  sense_reg [PORT_COUNT];
    logic [7:0]  hits_reg;
    logic [7:0]  hits_next;
    logic [2:0]  port_reg;

    logic [2:0]        slot3;
    logic [SLOT_W-1:0] slot;
    logic              port_ok;
    logic [7:0]        prev_sel;
    logic [7:0]        sense_sel;
    logic [7:0]        en_sel;
    logic [7:0]        both_sel;
    logic [7:0]        new_hits;
    logic [7:0]        hits_rest;
    logic [31:0]       falling_src;
    logic              cfg_hit;

    assign slot3   = port_number - 3'd1;
    assign slot    = slot3[SLOT_W-1:0];
    assign port_ok = (port_number != 3'd0) && (32'(port_number) <= 32'(PORT_COUNT));

    assign prev_sel  = prev_reg[slot];
    assign sense_sel = sense_reg[slot];
    assign en_sel    = port_byte(enable_reg, slot3);
    assign both_sel  = port_byte(both_reg, slot3);

    // sense 1 = falling (1 -> 0), sense 0 = rising (0 -> 1)
    assign new_hits = port_ok
        ? (en_sel & ((sense_sel & prev_sel & ~pin_levels) |
                     (~sense_sel & ~prev_sel & pin_levels)))
        : 8'h00;

    assign hits_rest = hits_reg & (hits_reg - 8'd1);

    assign status.new_any    = (new_hits != 8'h00);
    assign status.rest_empty = (hits_rest == 8'h00);

    assign event_port = port_reg;
    assign event_pin  = lowest_pin(hits_reg);
    assign last_event = (hits_rest == 8'h00);

    assign cfg_hit     = cfg_we && ((cfg_index == CFG_IRQ_ENABLE) ||
                                    (cfg_index == CFG_FALLING_SEL) ||
                                    (cfg_index == CFG_BOTH_EDGES));
    assign falling_src = (cfg_index == CFG_FALLING_SEL) ? cfg_data : falling_reg;

    always_comb
    begin
        hits_next = hits_reg;
        if (cmd.load)
        begin
            hits_next = new_hits;
        end
        else if (cmd.pop)
        begin
            hits_next = hits_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 32'h0;
            falling_reg <= 32'h0;
            both_reg    <= 32'h0;
            hits_reg    <= 8'h00;
            for (int s = 0; s < PORT_COUNT; s++)
            begin
                prev_reg[s]  <= 8'hFF;
                sense_reg[s] <= 8'h00;
            end
        end
        else
        begin
            hits_reg <= hits_next;
            if (cfg_hit)
            begin
                case (cfg_index)
                    CFG_IRQ_ENABLE:  enable_reg  <= cfg_data;
                    CFG_FALLING_SEL: falling_reg <= cfg_data;
                    CFG_BOTH_EDGES:  both_reg    <= cfg_data;
                    default:         enable_reg  <= enable_reg;
                endcase
                // any register write reloads every port's sense
                for (int s = 0; s < PORT_COUNT; s++)
                begin
                    sense_reg[s] <= port_byte(falling_src, 3'(s));
                end
            end
            else if (cmd.load && port_ok)
            begin
                prev_reg[slot]  <= pin_levels;
                sense_reg[slot] <= sense_sel ^ (new_hits & both_sel);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            port_reg <= port_number;
        end
    end

endmodule

// ===== hw/rtl/gpio_edge_interrupt_events_top.sv =====
// Top level of the GPIO edge interrupt event block.
// Instantiates gie_ctrl and gie_datapath; depends on gie_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  sample   | in_valid / in_stall    | port_number[2:0], pin_levels[7:0]
//  event    | out_valid / out_stall  | event_port[2:0], event_pin[2:0],
//           |                        | last_event
//  config   | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[31:0]
//
// A sample transfers when in_valid is high and in_stall is low; edge
// detection and the per-port state update happen at that edge. Its events
// then leave one per cycle, while out_stall is low, from the pending-pin
// register, lowest pin first; a sample raises one to eight events or none.
// The next sample transfers on the same edge as the final event.
// Reset (rst_n low, asynchronous) clears the masks and edge sense and sets
// all previous levels high. out_stall holds the current event steady;
// in_stall is high while events of an earlier sample are pending.
// Config writes are always ready; a write to a listed index reloads the edge sense of every port.
module gpio_edge_interrupt_events_top
    import gie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  port_number,
    input  logic [7:0]  pin_levels,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_port,
    output logic [2:0]  event_pin,
    output logic        last_event,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    gie_cmd_t    cmd;
    gie_status_t status;

    assign cfg_ready = 1'b1;

    gie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gie_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .port_number (port_number),
        .pin_levels  (pin_levels),
        .event_port  (event_port),
        .event_pin   (event_pin),
        .last_event  (last_event)
    );

endmodule

// ===== tb/tb_gpio_edge_interrupt_events_top.sv =====
// Self-checking testbench for gpio_edge_interrupt_events_top: directed table,
// then randomized phases, each event checked against a behavioral predictor.
// Depends on gie_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_gpio_edge_interrupt_events_top
    import gie_pkg::*;
();

    localparam int           CYCLE_LIMIT   = 500000;
    localparam int           IDLE_SETTLE   = 4;
    localparam int           TAIL_CYCLES   = 20;
    localparam int           HOLD_OFF_LEN  = 400;   // long receiver hold-off
    localparam int           PHASE_COUNT   = 6;
    localparam int           PHASE_SAMPLES = 66;
    localparam logic [1:0]   CFG_UNLISTED  = 2'd3;  // no register behind this index

    typedef enum logic { ROW_SAMPLE, ROW_CONFIG } row_kind_t;

    // One directed row: a sample, or a register write. When 'typed' is set, the
    // events are taken from exp_pins instead of the predictor.
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic [2:0]  port;
        logic [7:0]  levels;
        bit          typed;
        logic [7:0]  exp_pins;
    } stim_row_t;

    typedef struct {
        logic [2:0] port;
        logic [2:0] pin;
        logic       is_last;
    } pin_event_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  port_number = 3'd0;
    logic [7:0]  pin_levels = 8'h00;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_port;
    logic [2:0]  event_pin;
    logic        last_event;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'h0;

    // Receiver stall = per-event random stall OR the long pressure hold-off,
    // each owned by its own process.
    logic        rx_stall = 1'b0;
    logic        rx_hold_off = 1'b0;
    assign out_stall = rx_stall | rx_hold_off;

    always #1 clk = ~clk;

    gpio_edge_interrupt_events_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .port_number (port_number),
        .pin_levels  (pin_levels),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_port  (event_port),
        .event_pin   (event_pin),
        .last_event  (last_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: masks plus per-port last levels and edge sense
    // ------------------------------------------------------------------
    logic [31:0] irq_en   = 32'h0;
    logic [31:0] fall_sel = 32'h0;
    logic [31:0] both_sel = 32'h0;
    logic [7:0]  pin_prev  [PORT_COUNT];
    logic [7:0]  pin_sense [PORT_COUNT];

    pin_event_t  pending_events [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          random_started = 1'b0;
    bit          tx_steady = 1'b0;   // sender: no gaps while set
    bit          rx_steady = 1'b0;   // receiver: no stalls while set

    function automatic logic [7:0] mask_byte(input logic [31:0] mask, input int slot);
        mask_byte = (slot < CFG_PORTS) ? mask[slot*8 +: 8] : 8'h00;
    endfunction

    // Register write: store it, then every port's edge sense restarts from the
    // falling-select mask. Unlisted indexes change nothing.
    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        bit listed;
        listed = 1'b1;
        case (idx)
            CFG_IRQ_ENABLE:  irq_en   = val;
            CFG_FALLING_SEL: fall_sel = val;
            CFG_BOTH_EDGES:  both_sel = val;
            default:         listed = 1'b0;
        endcase
        if (listed)
        begin
            for (int s = 0; s < PORT_COUNT; s++)
            begin
                pin_sense[s] = mask_byte(fall_sel, s);
            end
        end
    endfunction

    // Edge detect for one sample; updates the port state, returns the pins hit.
    function automatic logic [7:0] fire_and_update(input logic [2:0] port,
                                                   input logic [7:0] levels);
        int         s;
        logic [7:0] prev, sense, hits;
        if (port == 3'd0 || int'(port) > PORT_COUNT)
        begin
            return 8'h00;
        end
        s     = int'(port) - 1;
        prev  = pin_prev[s];
        sense = pin_sense[s];
        // sense 1: falling (1 -> 0), sense 0: rising (0 -> 1)
        hits  = mask_byte(irq_en, s) & ((sense & prev & ~levels) | (~sense & ~prev & levels));
        pin_prev[s]  = levels;
        pin_sense[s] = sense ^ (hits & mask_byte(both_sel, s));
        return hits;
    endfunction

    // Expected events of one sample: lowest pin first, final one marked.
    function automatic void queue_events(input logic [2:0] port, input logic [7:0] pins);
        int         n;
        pin_event_t ev;
        n = pending_events.size();
        for (int p = 0; p < 8; p++)
        begin
            if (pins[p])
            begin
                ev.port    = port;
                ev.pin     = 3'(p);
                ev.is_last = 1'b0;
                pending_events.push_back(ev);
            end
        end
        if (pending_events.size() > n)
        begin
            pending_events[pending_events.size() - 1].is_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called at a falling edge, returns at a falling edge with
    // in_valid still high, so back-to-back samples need no drop.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [2:0] port, input logic [7:0] levels,
                               input bit typed, input logic [7:0] exp_pins);
        int         gap;
        logic [7:0] hits;
        cfg_valid <= 1'b0;
        if ($urandom_range(0, 31) == 0)
        begin
            tx_steady = ~tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        port_number <= port;
        pin_levels  <= levels;
        do @(posedge clk); while (in_stall);
        // transfer at this edge
        hits = fire_and_update(port, levels);
        queue_events(port, typed ? exp_pins : hits);
        @(negedge clk);
    endtask

    // Register write; cfg_valid stays high for a following write and is
    // dropped by the next sample.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
    endtask

    // Stop offering, wait for every expected event, then let the block settle.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_levels();
        case ($urandom_range(0, 9))
            0:       rand_levels = 8'h00;
            1:       rand_levels = 8'hFF;
            default: rand_levels = 8'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_port();
        case ($urandom_range(0, 15))
            0:       rand_port = 3'd0;
            1:       rand_port = 3'($urandom_range(PORT_COUNT + 1, 7));
            default: rand_port = 3'($urandom_range(1, PORT_COUNT));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    localparam int DIR_ROWS = 34;
    stim_row_t dir_rows [DIR_ROWS] = '{
        // after reset every pin is disabled
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h00, 1'b1, 8'h00},
        // port zero and ports past the count never fire
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd0, 8'hFF, 1'b1, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd5, 8'hAA, 1'b1, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd7, 8'h55, 1'b1, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd6, 8'hFF, 1'b1, 8'h00},
        // write to an unlisted index is dropped: still all disabled
        '{ROW_CONFIG, CFG_UNLISTED,    32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'hFF, 1'b1, 8'h00},
        '{ROW_CONFIG, CFG_IRQ_ENABLE,  32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_CONFIG, CFG_FALLING_SEL, 32'h0000_0000, 3'd0, 8'h00, 1'b0, 8'h00},
        // rising sense: falling edges ignored, then all eight pins fire
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd2, 8'h00, 1'b1, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd2, 8'hFF, 1'b1, 8'hFF},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h00, 1'b1, 8'h00},
        // no change, no event
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h00, 1'b1, 8'h00},
        '{ROW_CONFIG, CFG_FALLING_SEL, 32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0, 8'h00},
        // falling sense from pulled-up reset levels
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd3, 8'h00, 1'b1, 8'hFF},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd4, 8'h00, 1'b1, 8'hFF},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd4, 8'hFF, 1'b1, 8'h00},
        // both-edges on the low nibble of each port
        '{ROW_CONFIG, CFG_BOTH_EDGES,  32'h0F0F_0F0F, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'hFF, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h00, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'hFF, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h00, 1'b0, 8'h00},
        // sparse enables, rising sense
        '{ROW_CONFIG, CFG_IRQ_ENABLE,  32'h8142_2418, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_CONFIG, CFG_FALLING_SEL, 32'h0000_0000, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd3, 8'h55, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd3, 8'hAA, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd4, 8'hF0, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd4, 8'h0F, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd2, 8'h3C, 1'b0, 8'h00},
        // both-edges everywhere
        '{ROW_CONFIG, CFG_BOTH_EDGES,  32'hFFFF_FFFF, 3'd0, 8'h00, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd2, 8'hC3, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd2, 8'h3C, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h80, 1'b0, 8'h00},
        '{ROW_SAMPLE, CFG_IRQ_ENABLE,  32'h0,         3'd1, 8'h01, 1'b0, 8'h00}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        row_kind_t   prev_kind;
        logic [31:0] en_val, fall_val, both_val;

        for (int s = 0; s < PORT_COUNT; s++)
        begin
            pin_prev[s]  = 8'hFF;
            pin_sense[s] = 8'h00;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part; the block must be idle before any register write
        prev_kind = ROW_SAMPLE;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_CONFIG)
            begin
                if (prev_kind == ROW_SAMPLE)
                begin
                    drain(IDLE_SETTLE);
                end
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end
            else
            begin
                send_sample(dir_rows[r].port, dir_rows[r].levels,
                            dir_rows[r].typed, dir_rows[r].exp_pins);
            end
            prev_kind = dir_rows[r].kind;
        end

        // random phases, each with all three registers rewritten
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain(IDLE_SETTLE);
            en_val   = $urandom;
            fall_val = $urandom;
            both_val = $urandom;
            case (ph)
                0: begin en_val = 32'hFFFF_FFFF; both_val = 32'h0; end
                2: begin en_val = 32'hFFFF_FFFF; fall_val = 32'hFFFF_FFFF;
                         both_val = 32'hFFFF_FFFF; end
                3: begin fall_val = 32'h0; both_val = 32'hFFFF_FFFF; end
                4: en_val = 32'hFFFF_FFFF;
                5: both_val = 32'h0;
                default: ;
            endcase
            write_reg(CFG_IRQ_ENABLE,  en_val);
            write_reg(CFG_FALLING_SEL, fall_val);
            write_reg(CFG_BOTH_EDGES,  both_val);
            // samples are being offered from here on
            random_started = 1'b1;
            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                send_sample(rand_port(), rand_levels(), 1'b0, 8'h00);
            end
        end

        drain(TAIL_CYCLES);
        if (mismatches == 0 && pending_events.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall before each event, with stall-free stretches
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                rx_steady = ~rx_steady;
            end
            hold = rx_steady ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                rx_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rx_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    // Pressure: one long hold-off early in the random part, so pending events
    // back up and the block stalls incoming samples.
    initial
    begin
        wait (random_started);
        repeat (20) @(negedge clk);
        rx_hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(negedge clk);
        rx_hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Event checker: each transfer against the oldest expectation
    // ------------------------------------------------------------------
    pin_event_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected event: port %0d pin %0d last %0b",
                             event_port, event_pin, last_event);
                end
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_port !== want.port || event_pin !== want.pin ||
                    last_event !== want.is_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("event mismatch: exp port %0d pin %0d last %0b, got port %0d pin %0d last %0b",
                                 want.port, want.pin, want.is_last,
                                 event_port, event_pin, last_event);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
